@@ design/saoe_pkg.sv @@
// Package for the slot allocator with oldest-stamp eviction.
// Holds sizes, action codes, controller states and the structs passed along the
// chain of slot cells. Used by every other file of the block.
`default_nettype none

package saoe_pkg;

  localparam int NUM_SLOTS      = 16;
  localparam int CLIENT_ID_BITS = 16;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int ID_W    = CLIENT_ID_BITS;
  localparam int STAMP_W = 32;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_DEREGISTER = 2'd1,
    ACT_RESERVE    = 2'd2,
    ACT_LOOKUP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  pos;
    logic               cand_valid;
    logic [SLOT_W-1:0]  cand_slot;
    logic [STAMP_W-1:0] cand_stamp;
    logic [ID_W-1:0]    cand_owner;
  } scan_rec_t;

  // update broadcast to the cells at the end of a transaction
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  idx;
    logic               in_use;
    logic               reserved;
    logic [ID_W-1:0]    owner;
    logic               stamp_we;
    logic [STAMP_W-1:0] stamp;
  } slot_wr_t;

endpackage

`default_nettype wire

@@ design/saoe_cell.sv @@
// One slot cell: owner, stamp and flags of a single slot.
// Updates the passing search record (owner match, oldest unreserved stamp).
// Depends on saoe_pkg.
`default_nettype none

module saoe_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire saoe_pkg::scan_rec_t rec_in,
  output saoe_pkg::scan_rec_t      rec_out,
  input  wire logic                wr_en,
  input  wire saoe_pkg::slot_wr_t  wr
);
  import saoe_pkg::*;

  logic               in_use;
  logic               reserved;
  logic [ID_W-1:0]    owner;
  logic [STAMP_W-1:0] stamp;
  scan_rec_t          rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= 1'b0;
      reserved <= 1'b0;
    end else if (wr_en) begin
      in_use   <= wr.in_use;
      reserved <= wr.reserved;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner <= wr.owner;
    end
    if (wr_en && wr.stamp_we) begin
      stamp <= wr.stamp;
    end
  end

  always_comb begin
    rec_next     = rec_in;
    rec_next.pos = rec_in.pos + 1'b1;
    if (in_use && (owner == rec_in.id) && !rec_in.hit) begin
      rec_next.hit      = 1'b1;
      rec_next.hit_slot = rec_in.pos;
    end
    // strict compare: on a tie the lower slot, seen first, stays
    if (in_use && !reserved && (!rec_in.cand_valid || (stamp < rec_in.cand_stamp))) begin
      rec_next.cand_valid = 1'b1;
      rec_next.cand_slot  = rec_in.pos;
      rec_next.cand_stamp = stamp;
      rec_next.cand_owner = owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
    end
  end

endmodule

`default_nettype wire

@@ design/saoe_free_fifo.sv @@
// Free-slot queue: circular buffer of slot numbers, full of slots in order at reset.
// Pop from the head, push at the tail; a push into a full queue is dropped.
// Depends on saoe_pkg.
`default_nettype none

module saoe_free_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pop,
  input  wire logic                        push,
  input  wire logic [saoe_pkg::SLOT_W-1:0] push_slot,
  output logic      [saoe_pkg::SLOT_W-1:0] head_slot,
  output logic                             empty
);
  import saoe_pkg::*;

  logic [SLOT_W-1:0] fifo [NUM_SLOTS];
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic              full;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(NUM_SLOTS));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_slot = fifo[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        fifo[i] <= SLOT_W'(i);
      end
    end else if (do_push) begin
      fifo[tail] <= push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= CNT_W'(NUM_SLOTS);
    end else begin
      if (do_pop) begin
        head <= (head == SLOT_W'(NUM_SLOTS - 1)) ? '0 : head + 1'b1;
      end
      if (do_push) begin
        tail <= (tail == SLOT_W'(NUM_SLOTS - 1)) ? '0 : tail + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/slot_allocator_oldest_eviction.sv @@
// Slot allocator with oldest-stamp eviction.
// Input stream (s_*): one request per transaction: action, client id, current time.
// Output stream (m_*): exactly one answer per request, in request order.
// A request is taken only while the block is idle. It then sends a search record
// down a row of NUM_SLOTS slot cells, one cell per cycle, which finds the slot the
// client holds and the oldest unreserved slot. The finish state then commits the
// update and loads the output register once that register is free. The next
// request is taken only after the block is back in idle, so one request is
// finished before the next is accepted.
// Registration and reservation take the head of the free-slot queue; with the queue
// empty they evict the unreserved slot with the smallest stamp (lowest slot on a tie).
// Reset empties every slot and fills the free queue with slots in order;
// requests are taken from the first cycle after reset.
// If the receiver stalls, the answer is held in the output register and a new
// request can still be taken; its answer waits until the register is free.
// Depends on saoe_pkg, saoe_cell and saoe_free_fifo.
`default_nettype none

module slot_allocator_oldest_eviction (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // action [1:0], client_id [17:2], now_ticks [49:18], zero fill [55:50]
  input  wire logic [saoe_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // ok [0], slot [4:1], evicted [5], evicted_client [21:6], cleared [22], zero [23]
  output logic      [saoe_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import saoe_pkg::*;

  state_t             state;
  state_t             state_next;
  action_t            act;
  logic [ID_W-1:0]    id;
  logic [STAMP_W-1:0] now;
  logic               launch;
  scan_rec_t          fin;

  scan_rec_t          chain [NUM_SLOTS+1];
  slot_wr_t           wr;
  logic               fifo_pop;
  logic               fifo_push;
  logic [SLOT_W-1:0]  fifo_head;
  logic               fifo_empty;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               res_ok;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_ev;
  logic [ID_W-1:0]    res_ev_id;
  logic               res_cleared;
  logic [31:0]        id_wide;
  logic [31:0]        slot_wide;
  logic [31:0]        ev_wide;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign id_wide  = 32'(s_tdata[17:2]);

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action_t'(s_tdata[1:0]);
      id  <= id_wide[ID_W-1:0];
      now <= s_tdata[49:18];
    end
    if ((state == ST_SCAN) && chain[NUM_SLOTS].valid) begin
      fin <= chain[NUM_SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:   if (chain[NUM_SLOTS].valid) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = launch;
    chain[0].id         = id;
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    saoe_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .rec_in (chain[i]),
      .rec_out(chain[i+1]),
      .wr_en  (wr.en && (wr.idx == SLOT_W'(i))),
      .wr     (wr)
    );
  end

  saoe_free_fifo u_free (
    .clk      (clk),
    .rst      (rst),
    .pop      (fifo_pop),
    .push     (fifo_push),
    .push_slot(fin.hit_slot),
    .head_slot(fifo_head),
    .empty    (fifo_empty)
  );

  // outcome of the finished search and the update it commits
  always_comb begin
    s_tready    = (state == ST_IDLE);
    out_load    = (state == ST_FINISH) && out_free;
    res_ok      = 1'b0;
    res_slot    = '0;
    res_ev      = 1'b0;
    res_ev_id   = '0;
    res_cleared = 1'b0;
    fifo_pop    = 1'b0;
    fifo_push   = 1'b0;
    wr          = '0;
    wr.owner    = id;
    wr.stamp    = now;
    case (act)
      ACT_REGISTER, ACT_RESERVE: begin
        if (!fin.hit) begin
          if (!fifo_empty) begin
            res_ok   = 1'b1;
            res_slot = fifo_head;
            fifo_pop = out_load;
          end else if (fin.cand_valid) begin
            res_ok      = 1'b1;
            res_slot    = fin.cand_slot;
            res_ev      = 1'b1;
            res_ev_id   = fin.cand_owner;
            res_cleared = 1'b1;
          end
          wr.en       = out_load && res_ok;
          wr.idx      = res_slot;
          wr.in_use   = 1'b1;
          wr.reserved = (act == ACT_RESERVE);
          wr.stamp_we = (act == ACT_REGISTER);
        end
      end
      ACT_DEREGISTER: begin
        if (fin.hit) begin
          res_ok      = 1'b1;
          res_slot    = fin.hit_slot;
          res_cleared = 1'b1;
          fifo_push   = out_load;
          wr.en       = out_load;
          wr.idx      = fin.hit_slot;
        end
      end
      ACT_LOOKUP: begin
        if (fin.hit) begin
          res_ok   = 1'b1;
          res_slot = fin.hit_slot;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign slot_wide = 32'(res_slot);
  assign ev_wide   = 32'(res_ev_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, res_cleared, ev_wide[15:0], res_ev, slot_wide[3:0], res_ok};
    end
  end

  a_chain_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_SLOTS].valid |-> (state == ST_SCAN))
    else $error("search record left the cell row outside the scan");

  a_load_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("answer loaded without a finished search");

  a_evict_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_ev) |-> (fifo_empty && !fifo_pop))
    else $error("eviction while free slots remain");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("pop from empty free-slot queue");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == ST_FINISH) ##1 (state == ST_IDLE))
    else $error("slot update outside the commit cycle");

endmodule

`default_nettype wire
